// ===== design/djs_pkg.sv =====
// ----------------------------------------------------------------------------
// djs_pkg: shared types and constants for the deadline job selector
// Sizes of the job store, the profit heap and the result fields.
// ----------------------------------------------------------------------------
package djs_pkg;
  localparam int unsigned MaxJobs    = 1024;
  localparam int unsigned IdxBits    = $clog2(MaxJobs);
  localparam int unsigned CntBits    = IdxBits + 1;
  localparam int unsigned DlBits     = 11;
  localparam int unsigned ProfitBits = 16;
  localparam int unsigned TotalBits  = 26;

  typedef logic [IdxBits-1:0]    idx_t;
  typedef logic [CntBits-1:0]    cnt_t;
  typedef logic [DlBits-1:0]     dl_t;
  typedef logic [ProfitBits-1:0] profit_t;
  typedef logic [TotalBits-1:0]  total_t;

  typedef struct packed {
    dl_t     deadline;
    profit_t profit;
  } job_t;

  // sort order: ascending deadline, then descending profit
  function automatic logic job_before(job_t a, job_t b);
    if (a.deadline != b.deadline) begin
      return a.deadline < b.deadline;
    end
    return a.profit > b.profit;
  endfunction
endpackage

// ===== design/djs_ram.sv =====
// ----------------------------------------------------------------------------
// djs_ram: single-port synchronous memory
// One write and one registered read per cycle, both at the same address.
// ----------------------------------------------------------------------------
module djs_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // write, and read into the output register
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

// ===== design/deadline_job_selector.sv =====
// ----------------------------------------------------------------------------
// deadline_job_selector: greedy job sequencing with deadlines
// Loads jobs, sorts them and picks the best set with a min-heap of profits.
// ----------------------------------------------------------------------------
// Usage: a job transaction is taken at a clock edge with start high and
// busy low. Jobs that are not marked last are taken one per cycle and are
// written into the job store. The job marked last_job_i closes the set: the
// block raises busy, insertion-sorts the store, runs the heap pass and sums
// the heap, then shows chosen_count_o, profit_total_o and overflow_o with
// done_o high for one cycle. The receiver cannot stall.
// After the last job, the single-port store and heap memories allow one
// access per cycle: the sort does one read and one write per shift, each
// heap step walks the tree level by level, and the sum reads the heap one
// entry at a time.
// Jobs beyond 1024 are dropped and flagged in overflow_o. Reset clears the
// job count, heap size and drop flag; memories need no clearing.
// ----------------------------------------------------------------------------
module deadline_job_selector (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  djs_pkg::dl_t          job_deadline_i,
  input  djs_pkg::profit_t      job_profit_i,
  input  logic                  last_job_i,
  output logic                  done_o,
  output djs_pkg::cnt_t         chosen_count_o,
  output djs_pkg::total_t       profit_total_o,
  output logic                  overflow_o
);
  import djs_pkg::*;

  typedef enum logic [4:0] {
    S_LOAD, S_SO_RD, S_SO_KEY, S_SO_PRV, S_SO_CMP, S_SO_WR,
    S_SC_RD, S_SC_JOB, S_SC_TOP, S_SC_DEC,
    S_PU_RD, S_PU_CMP,
    S_RT_RDL, S_RT_RDR, S_RT_WL, S_RT_CMP,
    S_SU_RD, S_SU_ACC, S_DONE
  } state_e;

  state_e  state_q;
  cnt_t    loaded_q, heap_size_q, i_q, j_q, k_q, m_q;
  logic    drop_q;
  job_t    key_q;
  profit_t left_q, hv_q;
  total_t  sum_q;

  // memory ports
  logic    st_we, hp_we;
  idx_t    st_addr, hp_addr;
  job_t    st_wdata, st_rdata;
  profit_t hp_wdata, hp_rdata;

  djs_ram #(.Width($bits(job_t)), .Depth(MaxJobs)) u_store (
    .clk_i, .we_i(st_we), .addr_i(st_addr), .wdata_i(st_wdata), .rdata_o(st_rdata)
  );
  djs_ram #(.Width(ProfitBits), .Depth(MaxJobs)) u_heap (
    .clk_i, .we_i(hp_we), .addr_i(hp_addr), .wdata_i(hp_wdata), .rdata_o(hp_rdata)
  );

  logic  accept;
  dl_t   dl_clamp;
  cnt_t  parent, lchild, rchild;
  job_t  prev_job;

  assign accept   = start && !busy;
  assign dl_clamp = (job_deadline_i > dl_t'(MaxJobs)) ? dl_t'(MaxJobs) : job_deadline_i;
  assign parent   = (k_q - cnt_t'(1)) >> 1;
  assign lchild   = {k_q[CntBits-2:0], 1'b1};
  assign rchild   = lchild + cnt_t'(1);
  assign prev_job = st_rdata;

  // memory address and write selection
  always_comb begin
    st_we    = 1'b0;
    st_addr  = idx_t'(0);
    st_wdata = key_q;
    hp_we    = 1'b0;
    hp_addr  = idx_t'(0);
    hp_wdata = hv_q;
    unique case (state_q)
      S_LOAD: begin
        st_we    = accept && (loaded_q < cnt_t'(MaxJobs));
        st_addr  = loaded_q[IdxBits-1:0];
        st_wdata = '{deadline: dl_clamp, profit: job_profit_i};
      end
      S_SO_RD:  st_addr = i_q[IdxBits-1:0];
      S_SO_PRV: st_addr = idx_t'(j_q - cnt_t'(1));
      S_SO_CMP: begin
        if (job_before(key_q, prev_job)) begin
          st_we    = 1'b1;
          st_addr  = j_q[IdxBits-1:0];
          st_wdata = prev_job;
        end
      end
      S_SO_WR: begin
        st_we   = 1'b1;
        st_addr = j_q[IdxBits-1:0];
      end
      S_SC_RD:  st_addr = i_q[IdxBits-1:0];
      S_SC_JOB: hp_addr = idx_t'(0);
      S_PU_RD:  hp_addr = parent[IdxBits-1:0];
      S_PU_CMP: begin
        hp_we   = 1'b1;
        hp_addr = k_q[IdxBits-1:0];
        if (k_q != cnt_t'(0) && hp_rdata > hv_q) begin
          hp_wdata = hp_rdata;
        end
      end
      S_RT_RDL: hp_addr = lchild[IdxBits-1:0];
      S_RT_RDR: hp_addr = rchild[IdxBits-1:0];
      S_RT_CMP: begin
        hp_we   = 1'b1;
        hp_addr = k_q[IdxBits-1:0];
        if (m_q != cnt_t'(0) && left_q < hv_q) begin
          hp_wdata = left_q;
        end
      end
      S_SU_RD:  hp_addr = i_q[IdxBits-1:0];
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_LOAD;
      loaded_q       <= '0;
      heap_size_q    <= '0;
      drop_q         <= 1'b0;
      i_q            <= '0;
      j_q            <= '0;
      k_q            <= '0;
      m_q            <= '0;
      key_q          <= '0;
      left_q         <= '0;
      hv_q           <= '0;
      sum_q          <= '0;
      done_o         <= 1'b0;
      chosen_count_o <= '0;
      profit_total_o <= '0;
      overflow_o     <= 1'b0;
    end else begin
      done_o <= 1'b0;
      unique case (state_q)
        S_LOAD: begin
          if (accept) begin
            if (loaded_q < cnt_t'(MaxJobs)) begin
              loaded_q <= loaded_q + cnt_t'(1);
            end else begin
              drop_q <= 1'b1;
            end
            if (last_job_i) begin
              i_q     <= cnt_t'(1);
              state_q <= S_SO_RD;
            end
          end
        end
        // insertion sort
        S_SO_RD: begin
          if (i_q >= loaded_q) begin
            i_q         <= '0;
            heap_size_q <= '0;
            state_q     <= S_SC_RD;
          end else begin
            state_q <= S_SO_KEY;
          end
        end
        S_SO_KEY: begin
          key_q   <= st_rdata;
          j_q     <= i_q;
          state_q <= (i_q == cnt_t'(0)) ? S_SO_WR : S_SO_PRV;
        end
        S_SO_PRV: state_q <= S_SO_CMP;
        S_SO_CMP: begin
          if (job_before(key_q, prev_job)) begin
            j_q     <= j_q - cnt_t'(1);
            state_q <= (j_q == cnt_t'(1)) ? S_SO_WR : S_SO_PRV;
          end else begin
            state_q <= S_SO_WR;
          end
        end
        S_SO_WR: begin
          i_q     <= i_q + cnt_t'(1);
          state_q <= S_SO_RD;
        end
        // heap pass over the sorted jobs
        S_SC_RD: begin
          if (i_q >= loaded_q) begin
            i_q     <= '0;
            sum_q   <= '0;
            state_q <= S_SU_RD;
          end else begin
            state_q <= S_SC_JOB;
          end
        end
        S_SC_JOB: begin
          hv_q <= st_rdata.profit;
          if (st_rdata.deadline == dl_t'(0)) begin
            state_q <= S_SC_DEC;
          end else if (heap_size_q < cnt_t'(st_rdata.deadline)) begin
            k_q         <= heap_size_q;
            heap_size_q <= heap_size_q + cnt_t'(1);
            state_q     <= (heap_size_q == cnt_t'(0)) ? S_PU_CMP : S_PU_RD;
          end else begin
            state_q <= S_SC_TOP;
          end
        end
        S_SC_TOP: begin
          if (hp_rdata < hv_q) begin
            k_q     <= '0;
            state_q <= S_RT_RDL;
          end else begin
            state_q <= S_SC_DEC;
          end
        end
        S_SC_DEC: begin
          i_q     <= i_q + cnt_t'(1);
          state_q <= S_SC_RD;
        end
        // sift up
        S_PU_RD: state_q <= S_PU_CMP;
        S_PU_CMP: begin
          if (k_q != cnt_t'(0) && hp_rdata > hv_q) begin
            k_q     <= parent;
            state_q <= (parent == cnt_t'(0)) ? S_PU_CMP : S_PU_RD;
          end else begin
            state_q <= S_SC_DEC;
          end
        end
        // sift down
        S_RT_RDL: begin
          m_q     <= '0;
          left_q  <= hv_q;
          state_q <= (lchild >= heap_size_q) ? S_RT_CMP : S_RT_RDR;
        end
        S_RT_RDR: begin
          left_q  <= hp_rdata;
          m_q     <= lchild;
          state_q <= (rchild < heap_size_q) ? S_RT_WL : S_RT_CMP;
        end
        S_RT_WL: begin
          if (hp_rdata < left_q) begin
            left_q <= hp_rdata;
            m_q    <= rchild;
          end
          state_q <= S_RT_CMP;
        end
        S_RT_CMP: begin
          if (m_q != cnt_t'(0) && left_q < hv_q) begin
            k_q     <= m_q;
            state_q <= S_RT_RDL;
          end else begin
            state_q <= S_SC_DEC;
          end
        end
        // sum the heap
        S_SU_RD: begin
          state_q <= (i_q >= heap_size_q) ? S_DONE : S_SU_ACC;
        end
        S_SU_ACC: begin
          sum_q   <= sum_q + total_t'(hp_rdata);
          i_q     <= i_q + cnt_t'(1);
          state_q <= S_SU_RD;
        end
        S_DONE: begin
          done_o         <= 1'b1;
          chosen_count_o <= heap_size_q;
          profit_total_o <= sum_q;
          overflow_o     <= drop_q;
          loaded_q       <= '0;
          heap_size_q    <= '0;
          drop_q         <= 1'b0;
          state_q        <= S_LOAD;
        end
        default: state_q <= S_LOAD;
      endcase
    end
  end

  assign busy = (state_q != S_LOAD);
endmodule

// ===== design/djs_checker.sv =====
// ----------------------------------------------------------------------------
// djs_checker: port-level checks for the deadline job selector
// Watches the command handshake and the result strobe.
// ----------------------------------------------------------------------------
module djs_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start,
  input logic                busy,
  input logic                last_job_i,
  input logic                done_o,
  input djs_pkg::cnt_t       chosen_count_o
);
  // a last-job transaction makes the block busy
  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && last_job_i |=> busy) else $error("no busy after last job");

  // a plain job transaction leaves the block free
  a_job_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && !last_job_i |=> !busy) else $error("busy after plain job");

  // result strobe ends the busy period
  a_done_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy && $past(busy)) else $error("strobe outside busy end");

  // result strobe lasts one cycle
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("strobe longer than one cycle");

  // count stays within capacity
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> chosen_count_o <= djs_pkg::cnt_t'(djs_pkg::MaxJobs))
    else $error("count above capacity");
endmodule

bind deadline_job_selector djs_checker u_djs_checker (
  .clk_i, .rst_ni, .start, .busy, .last_job_i, .done_o, .chosen_count_o
);
